### rtl/etcb_pkg.sv
// shared types and constants for the edge trigger capture buffer
// used by the top level, etcb_front and etcb_back in rtl/; etcb_fifo does not use it
`default_nettype none

package etcb_pkg;

    localparam int RingDepthDefault     = 1024;
    localparam int ReadoutLengthDefault = 300;
    localparam int PinCount             = 16;
    localparam int QueueDepth           = 4;
    localparam int WordWidth            = 16;
    localparam int CountWidth           = 10;
    localparam int AddrMaxWidth         = 16;
    localparam int ApbAddrWidth         = 4;
    localparam int ApbDataWidth         = 32;

    localparam logic [CountWidth-1:0] PostResetDefault = 10'd300;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_READ   = 2'd1,
        OP_ARM    = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_POST = 2'd1,
        PH_DONE = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        MEM_NONE  = 2'd0,
        MEM_WRITE = 2'd1,
        MEM_READ  = 2'd2
    } t_mem_op;

    typedef enum logic [1:0] {
        REG_TRIGGER_PIN    = 2'd0,
        REG_TRIGGER_RISING = 2'd1,
        REG_POST_SAMPLES   = 2'd2,
        REG_CAPTURE_ENABLE = 2'd3
    } t_reg;

    typedef struct packed {
        logic [3:0]            trigger_pin;
        logic                  trigger_rising;
        logic [CountWidth-1:0] post_trigger_samples;
        logic                  capture_enable;
    } t_cfg;

    typedef struct packed {
        t_mem_op                 mem_op;
        logic [AddrMaxWidth-1:0] addr;
        logic [WordWidth-1:0]    data;
        t_phase                  phase;
        logic                    seen;
    } t_cmd;

    typedef struct packed {
        logic [WordWidth-1:0] word;
        t_phase               phase;
        logic                 seen;
    } t_result;

endpackage

`default_nettype wire

### rtl/edge_trigger_capture_buffer.sv
// top level of the edge trigger capture buffer: config registers, front, queue, back
// depends on etcb_pkg, etcb_fifo, etcb_front, etcb_back
//
// channel   direction  handshake          payload
// input     in         push / full        i_operation, i_pin_levels
// result    out        empty / pop        o_read_word, o_phase, o_trigger_seen
// config    in/out     psel/penable/...   paddr, pwdata, prdata
//
// one word accepted per cycle while full is low; a word's result reaches the result ports
// after it is accepted, through the command queue, the ring memory read stage and the result queue
// full rises only when the command queue backs up behind a stalled result side
// synchronous active-low reset clears all control state; ring contents are
// undefined until written and get no clearing pass
`default_nettype none

module edge_trigger_capture_buffer #(
    parameter int RING_DEPTH     = etcb_pkg::RingDepthDefault,
    parameter int READOUT_LENGTH = etcb_pkg::ReadoutLengthDefault
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic [1:0]                          i_operation,
    input  wire logic [etcb_pkg::WordWidth-1:0]      i_pin_levels,
    output logic                                     empty,
    input  wire logic                                pop,
    output logic [etcb_pkg::WordWidth-1:0]           o_read_word,
    output logic [1:0]                               o_phase,
    output logic                                     o_trigger_seen,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [etcb_pkg::ApbAddrWidth-1:0]   paddr,
    input  wire logic [etcb_pkg::ApbDataWidth-1:0]   pwdata,
    output logic [etcb_pkg::ApbDataWidth-1:0]        prdata,
    output logic                                     pready
);

    localparam int CB = $bits(etcb_pkg::t_cmd);

    etcb_pkg::t_cfg     r_cfg;
    etcb_pkg::t_reg     w_reg;
    logic               w_cfg_write;
    logic               w_cmd_push;
    etcb_pkg::t_cmd     w_cmd_in;
    logic [CB-1:0]      w_cmd_in_bits;
    logic [CB-1:0]      w_cmd_out_bits;
    etcb_pkg::t_cmd     w_cmd_out;
    logic               w_cmd_full;
    logic               w_cmd_empty;
    logic               w_cmd_pop;
    logic [$clog2(etcb_pkg::QueueDepth+1)-1:0] w_cmd_count;
    etcb_pkg::t_result  w_result;

    assign pready      = 1'b1;
    assign w_reg       = etcb_pkg::t_reg'(paddr[3:2]);
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_pin          <= '0;
            r_cfg.trigger_rising       <= 1'b0;
            r_cfg.post_trigger_samples <= etcb_pkg::PostResetDefault;
            r_cfg.capture_enable       <= 1'b0;
        end else if (w_cfg_write) begin
            unique case (w_reg)
                etcb_pkg::REG_TRIGGER_PIN:    r_cfg.trigger_pin <= pwdata[3:0];
                etcb_pkg::REG_TRIGGER_RISING: r_cfg.trigger_rising <= pwdata[0];
                etcb_pkg::REG_POST_SAMPLES: begin
                    r_cfg.post_trigger_samples <= pwdata[etcb_pkg::CountWidth-1:0];
                end
                etcb_pkg::REG_CAPTURE_ENABLE: r_cfg.capture_enable <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_reg)
            etcb_pkg::REG_TRIGGER_PIN:    prdata[3:0] = r_cfg.trigger_pin;
            etcb_pkg::REG_TRIGGER_RISING: prdata[0] = r_cfg.trigger_rising;
            etcb_pkg::REG_POST_SAMPLES: begin
                prdata[etcb_pkg::CountWidth-1:0] = r_cfg.post_trigger_samples;
            end
            etcb_pkg::REG_CAPTURE_ENABLE: prdata[0] = r_cfg.capture_enable;
            default: prdata = '0;
        endcase
    end

    etcb_front #(
        .RING_DEPTH     (RING_DEPTH),
        .READOUT_LENGTH (READOUT_LENGTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_push       (push),
        .i_operation  (i_operation),
        .i_pin_levels (i_pin_levels),
        .i_queue_full (w_cmd_full),
        .o_cmd_push   (w_cmd_push),
        .o_cmd        (w_cmd_in)
    );

    assign w_cmd_in_bits = w_cmd_in;
    assign full          = w_cmd_full;

    etcb_fifo #(
        .WIDTH (CB),
        .DEPTH (etcb_pkg::QueueDepth)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_data  (w_cmd_in_bits),
        .o_full  (w_cmd_full),
        .i_pop   (w_cmd_pop),
        .o_data  (w_cmd_out_bits),
        .o_empty (w_cmd_empty),
        .o_count (w_cmd_count)
    );

    assign w_cmd_out = w_cmd_out_bits;

    etcb_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd_out),
        .i_cmd_empty (w_cmd_empty),
        .o_cmd_pop   (w_cmd_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (w_result)
    );

    assign o_read_word    = w_result.word;
    assign o_phase        = w_result.phase;
    assign o_trigger_seen = w_result.seen;

    // command queue depth is only watched through full and empty
    logic w_unused_count;
    assign w_unused_count = ^w_cmd_count;

endmodule

`default_nettype wire

### rtl/etcb_fifo.sv
// small register queue with push/full and pop/empty sides
// used between front and back and for the result words; no package needed
`default_nettype none

module etcb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_push,
    input  wire logic [WIDTH-1:0]             i_data,
    output logic                              o_full,
    input  wire logic                         i_pop,
    output logic [WIDTH-1:0]                  o_data,
    output logic                              o_empty,
    output logic [$clog2(DEPTH+1)-1:0]        o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, n_wr;
    logic [PW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_count, n_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (w_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

### rtl/etcb_front.sv
// front end: takes each word, runs the trigger and capture state, issues ring commands
// depends on etcb_pkg
`default_nettype none

module etcb_front #(
    parameter int RING_DEPTH     = etcb_pkg::RingDepthDefault,
    parameter int READOUT_LENGTH = etcb_pkg::ReadoutLengthDefault
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire etcb_pkg::t_cfg                   i_cfg,
    input  wire logic                             i_push,
    input  wire logic [1:0]                       i_operation,
    input  wire logic [etcb_pkg::WordWidth-1:0]   i_pin_levels,
    input  wire logic                             i_queue_full,
    output logic                                  o_cmd_push,
    output etcb_pkg::t_cmd                        o_cmd
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int RW = (READOUT_LENGTH > 1) ? $clog2(READOUT_LENGTH) : 1;
    localparam int CW = etcb_pkg::CountWidth;

    logic [AW-1:0]                     r_write_index, n_write_index;
    logic [etcb_pkg::WordWidth-1:0]    r_prev, n_prev;
    etcb_pkg::t_phase                  r_phase, n_phase;
    logic [CW-1:0]                     r_post_count, n_post_count;
    logic [RW-1:0]                     r_read_index, n_read_index;
    logic [AW-1:0]                     r_read_ring, n_read_ring;
    logic [CW-1:0]                     w_post_inc;
    logic                              w_accept;
    logic                              w_edge;
    logic                              w_bit_before;
    logic                              w_bit_now;
    logic                              w_seen;
    logic                              w_store;

    assign w_accept     = i_push && !i_queue_full;
    assign w_bit_before = r_prev[i_cfg.trigger_pin];
    assign w_bit_now    = i_pin_levels[i_cfg.trigger_pin];
    assign w_post_inc   = r_post_count + 1'b1;

    always_comb begin
        if (int'(i_cfg.trigger_pin) >= etcb_pkg::PinCount) begin
            w_edge = 1'b0;
        end else if (i_cfg.trigger_rising) begin
            w_edge = !w_bit_before && w_bit_now;
        end else begin
            w_edge = w_bit_before && !w_bit_now;
        end
    end

    always_comb begin
        n_write_index = r_write_index;
        n_prev        = r_prev;
        n_phase       = r_phase;
        n_post_count  = r_post_count;
        n_read_index  = r_read_index;
        n_read_ring   = r_read_ring;
        w_seen        = 1'b0;
        w_store       = 1'b0;
        o_cmd.mem_op  = etcb_pkg::MEM_NONE;
        o_cmd.addr    = '0;
        o_cmd.data    = i_pin_levels;
        case (i_operation)
            etcb_pkg::OP_SAMPLE: begin
                if (i_cfg.capture_enable && r_phase != etcb_pkg::PH_DONE) begin
                    w_store = 1'b1;
                    if (r_phase == etcb_pkg::PH_WAIT) begin
                        if (w_edge) begin
                            w_seen       = 1'b1;
                            n_post_count = '0;
                            n_phase      = (i_cfg.post_trigger_samples == '0) ?
                                           etcb_pkg::PH_DONE : etcb_pkg::PH_POST;
                        end
                    end else begin
                        n_post_count = w_post_inc;
                        if (w_post_inc >= i_cfg.post_trigger_samples) begin
                            n_phase = etcb_pkg::PH_DONE;
                        end
                    end
                end
            end
            etcb_pkg::OP_READ: begin
                o_cmd.mem_op = etcb_pkg::MEM_READ;
                o_cmd.addr   = etcb_pkg::AddrMaxWidth'(r_read_ring);
                if (r_read_index == RW'(READOUT_LENGTH - 1)) begin
                    n_read_index = '0;
                    n_read_ring  = '0;
                end else begin
                    n_read_index = r_read_index + 1'b1;
                    n_read_ring  = (r_read_ring == AW'(RING_DEPTH - 1)) ?
                                   '0 : r_read_ring + 1'b1;
                end
            end
            etcb_pkg::OP_ARM: begin
                n_phase      = etcb_pkg::PH_WAIT;
                n_post_count = '0;
            end
            default: begin
            end
        endcase
        if (w_store) begin
            o_cmd.mem_op  = etcb_pkg::MEM_WRITE;
            o_cmd.addr    = etcb_pkg::AddrMaxWidth'(r_write_index);
            n_prev        = i_pin_levels;
            n_write_index = (r_write_index == AW'(RING_DEPTH - 1)) ?
                            '0 : r_write_index + 1'b1;
        end
        o_cmd.phase = n_phase;
        o_cmd.seen  = w_seen;
    end

    assign o_cmd_push = w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_index <= '0;
            r_prev        <= '0;
            r_phase       <= etcb_pkg::PH_WAIT;
            r_post_count  <= '0;
            r_read_index  <= '0;
            r_read_ring   <= '0;
        end else if (w_accept) begin
            r_write_index <= n_write_index;
            r_prev        <= n_prev;
            r_phase       <= n_phase;
            r_post_count  <= n_post_count;
            r_read_index  <= n_read_index;
            r_read_ring   <= n_read_ring;
        end
    end

endmodule

`default_nettype wire

### rtl/etcb_back.sv
// back end: sample ring memory, registered read stage and result queue
// depends on etcb_pkg and etcb_fifo
`default_nettype none

module etcb_back #(
    parameter int RING_DEPTH = etcb_pkg::RingDepthDefault
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire etcb_pkg::t_cmd       i_cmd,
    input  wire logic                 i_cmd_empty,
    output logic                      o_cmd_pop,
    input  wire logic                 i_pop,
    output logic                      o_empty,
    output etcb_pkg::t_result         o_result
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int OD = etcb_pkg::QueueDepth;
    localparam int RB = $bits(etcb_pkg::t_result);

    logic [etcb_pkg::WordWidth-1:0] r_ring [RING_DEPTH];
    logic [etcb_pkg::WordWidth-1:0] r_rdata;
    logic                           r_s1_valid;
    etcb_pkg::t_cmd                 r_s1_cmd;
    logic                           w_issue;
    logic [$clog2(OD+1)-1:0]        w_out_count;
    logic                           w_out_full;
    etcb_pkg::t_result              w_res;
    logic [RB-1:0]                  w_res_bits;
    logic [AW-1:0]                  w_addr;

    // room in the result queue counts the word still in the read stage
    assign w_issue   = !i_cmd_empty && !w_out_full &&
                       ((int'(w_out_count) + int'(r_s1_valid)) < OD);
    assign o_cmd_pop = w_issue;
    assign w_addr    = i_cmd.addr[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_issue && i_cmd.mem_op == etcb_pkg::MEM_WRITE) begin
            r_ring[w_addr] <= i_cmd.data;
        end
        if (w_issue) begin
            r_rdata  <= r_ring[w_addr];
            r_s1_cmd <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_issue;
        end
    end

    always_comb begin
        w_res.word  = (r_s1_cmd.mem_op == etcb_pkg::MEM_READ) ? r_rdata : '0;
        w_res.phase = r_s1_cmd.phase;
        w_res.seen  = r_s1_cmd.seen;
    end

    assign w_res_bits = w_res;

    etcb_fifo #(
        .WIDTH (RB),
        .DEPTH (OD)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_valid),
        .i_data  (w_res_bits),
        .o_full  (w_out_full),
        .i_pop   (i_pop),
        .o_data  (o_result),
        .o_empty (o_empty),
        .o_count (w_out_count)
    );

endmodule

`default_nettype wire
